// ===== design/aesbe_pkg.sv =====
// Shared types, constants and round functions for the AES block encryptor.
// Used by the controller, the datapath and the top level; depends on nothing.
package aesbe_pkg;

	localparam int KEY_TABLE_WORDS = 30;
	localparam int BANK_DEPTH      = (KEY_TABLE_WORDS + 1) / 2;
	localparam int BANK_AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int RND_W           = 4;
	localparam int IDX_W           = 5;

	localparam logic [1:0] KL_128 = 2'd0;
	localparam logic [1:0] KL_192 = 2'd1;
	localparam logic [7:0] GF_POLY = 8'h1B;
	localparam logic [7:0] GF_TOP  = 8'h80;

	localparam logic [RND_W-1:0] NR_128 = 4'd10;
	localparam logic [RND_W-1:0] NR_192 = 4'd12;
	localparam logic [RND_W-1:0] NR_256 = 4'd14;

	localparam logic KIND_KEY   = 1'b0;
	localparam logic KIND_BLOCK = 1'b1;

	typedef struct packed {
		logic             load;
		logic             step;
		logic             first;
		logic             last;
		logic             key_we;
		logic [RND_W-1:0] rd_round;
	} dp_cmd_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [RND_W-1:0] round_count(input logic [1:0] kl);
		logic [RND_W-1:0] n;
		n = NR_256;
		if (kl == KL_128) n = NR_128;
		else if (kl == KL_192) n = NR_192;
		return n;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (((b & GF_TOP) != 8'h00) ? GF_POLY : 8'h00);
	endfunction

	// Byte i of the state sits at bits 127-8i; byte i is row i%4, column i/4.
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8*(r + 4*c) -: 8] = SBOX[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0]   a0, a1, a2, a3, al;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 32*c -: 8];
			a1 = s[119 - 32*c -: 8];
			a2 = s[111 - 32*c -: 8];
			a3 = s[103 - 32*c -: 8];
			al = a0 ^ a1 ^ a2 ^ a3;
			t[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			t[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			t[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			t[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

endpackage

// ===== design/aesbe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; used for the two round key banks.
module aesbe_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== design/aesbe_ctrl.sv =====
// Controller for the AES block encryptor: sequences the rounds of one item.
// Depends on aesbe_pkg.
module aesbe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               kind,
	input  logic [1:0]         key_length,
	input  logic               out_ready,
	output logic               in_ready,
	output logic               out_valid,
	output aesbe_pkg::dp_cmd_t cmd
);
	import aesbe_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t           state_q, state_d;
	logic [RND_W-1:0] rnd_q, rnd_d;
	logic             last;

	assign last = (rnd_q == round_count(key_length));

	always_comb begin
		state_d      = state_q;
		rnd_d        = rnd_q;
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		cmd          = '0;
		cmd.first    = (rnd_q == '0);
		cmd.last     = last;
		cmd.rd_round = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.key_we = in_valid && (kind == KIND_KEY);
				if (in_valid && (kind == KIND_BLOCK)) begin
					cmd.load = 1'b1;
					rnd_d    = '0;
					state_d  = S_RUN;
				end
			end
			S_RUN: begin
				// The key for the next round is fetched while this one is applied.
				cmd.step     = 1'b1;
				cmd.rd_round = rnd_q + 1'b1;
				rnd_d        = rnd_q + 1'b1;
				if (last) state_d = S_DONE;
			end
			S_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					rnd_d   = '0;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			rnd_q   <= rnd_d;
		end
	end
endmodule

// ===== design/aesbe_dp.sv =====
// Datapath for the AES block encryptor: round key banks, state register and round logic.
// Depends on aesbe_pkg and aesbe_ram.
module aesbe_dp (
	input  logic                          clk,
	input  aesbe_pkg::dp_cmd_t            cmd,
	input  logic [aesbe_pkg::IDX_W-1:0]   key_word_index,
	input  logic [63:0]                   key_word,
	input  logic [63:0]                   block_high,
	input  logic [63:0]                   block_low,
	output logic [63:0]                   cipher_high,
	output logic [63:0]                   cipher_low
);
	import aesbe_pkg::*;

	logic [127:0]       state_q, round_in, round_out;
	logic [63:0]        rk_even, rk_odd;
	logic               even_zero, odd_zero, even_zero_q, odd_zero_q;
	logic               wr_ok, we_even, we_odd;
	logic [BANK_AW-1:0] waddr, raddr;
	logic [127:0]       rkey_cur;

	// Writes beyond the table are dropped.
	assign wr_ok   = cmd.key_we && (32'(key_word_index) < KEY_TABLE_WORDS);
	assign we_even = wr_ok && !key_word_index[0];
	assign we_odd  = wr_ok && key_word_index[0];
	assign waddr   = key_word_index[BANK_AW:1];

	assign even_zero = (32'(cmd.rd_round) * 2 >= KEY_TABLE_WORDS);
	assign odd_zero  = (32'(cmd.rd_round) * 2 + 1 >= KEY_TABLE_WORDS);
	assign raddr     = even_zero ? '0 : cmd.rd_round[BANK_AW-1:0];

	aesbe_ram #(.WIDTH(64), .DEPTH(BANK_DEPTH)) u_bank_even (
		.clk(clk), .we(we_even), .waddr(waddr), .wdata(key_word),
		.raddr(raddr), .rdata(rk_even)
	);

	aesbe_ram #(.WIDTH(64), .DEPTH(BANK_DEPTH)) u_bank_odd (
		.clk(clk), .we(we_odd), .waddr(waddr), .wdata(key_word),
		.raddr(raddr), .rdata(rk_odd)
	);

	always_ff @(posedge clk) begin
		even_zero_q <= even_zero;
		odd_zero_q  <= odd_zero;
		if (cmd.load) state_q <= {block_high, block_low};
		else if (cmd.step) state_q <= round_out;
	end

	assign rkey_cur = {even_zero_q ? 64'h0 : rk_even, odd_zero_q ? 64'h0 : rk_odd};

	always_comb begin
		round_in = state_q;
		if (!cmd.first) begin
			round_in = sub_shift(state_q);
			if (!cmd.last) round_in = mix_cols(round_in);
		end
		round_out = round_in ^ rkey_cur;
	end

	assign cipher_high = state_q[127:64];
	assign cipher_low  = state_q[63:0];
endmodule

// ===== design/aes_block_encrypt.sv =====
// AES forward cipher over a stored expanded key schedule: one round per cycle.
// A block item is loaded into the state register, runs its rounds and then waits as the result;
// the next item is taken only once the result has been taken, so blocks never overlap.
// A key-write item is taken in the idle state. The rounds run in turn through the shared round logic.
// Reset clears the controller and key_length; the key table is undefined until written.
module aes_block_encrypt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [4:0]  key_word_index,
	input  logic [63:0] key_word,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low
);
	import aesbe_pkg::*;

	logic [1:0] key_length_q;
	dp_cmd_t    cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) key_length_q <= KL_128;
		else if (cfg_valid) key_length_q <= cfg_data;
	end

	aesbe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .kind(kind),
		.key_length(key_length_q), .out_ready(out_ready), .in_ready(in_ready),
		.out_valid(out_valid), .cmd(cmd)
	);

	aesbe_dp u_dp (
		.clk(clk), .cmd(cmd), .key_word_index(key_word_index), .key_word(key_word),
		.block_high(block_high), .block_low(block_low),
		.cipher_high(cipher_high), .cipher_low(cipher_low)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while a result waits");

	a_block_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind == KIND_BLOCK) |=> (!in_ready && !out_valid))
		else $error("block item did not start the round sequence");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (cmd.rd_round <= NR_256 + 1'b1))
		else $error("round counter ran past the last round");
endmodule

// ===== tb/sv/aes_block_encrypt_tb.sv =====
// Self-checking testbench for aes_block_encrypt: key-table writes and block encryption.
// Predicts ciphertext with its own AES forward cipher; depends on aesbe_pkg and the RTL.
module aes_block_encrypt_tb;
	import aesbe_pkg::*;

	class cipher_scoreboard;
		logic [63:0] want_high[$];
		logic [63:0] want_low[$];
		int          errors;

		function void note_block(logic [63:0] hi, logic [63:0] lo);
			want_high.push_back(hi);
			want_low.push_back(lo);
		endfunction

		function void check_cipher(logic [63:0] hi, logic [63:0] lo);
			logic [63:0] eh, el;
			if (want_high.size() == 0) begin
				$display("%0t: unexpected cipher item %h %h", $time, hi, lo);
				errors++;
				return;
			end
			eh = want_high.pop_front();
			el = want_low.pop_front();
			if (eh !== hi) begin
				$display("%0t: cipher_high expected %h actual %h", $time, eh, hi);
				errors++;
			end
			if (el !== lo) begin
				$display("%0t: cipher_low expected %h actual %h", $time, el, lo);
				errors++;
			end
		endfunction

		function int pending();
			return want_high.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = KIND_KEY;
	logic [4:0]  key_word_index = '0;
	logic [63:0] key_word = '0;
	logic [63:0] block_high = '0;
	logic [63:0] block_low = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] cipher_high;
	logic [63:0] cipher_low;

	aes_block_encrypt u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind),
		.key_word_index(key_word_index), .key_word(key_word),
		.block_high(block_high), .block_low(block_low),
		.out_valid(out_valid), .out_ready(out_ready),
		.cipher_high(cipher_high), .cipher_low(cipher_low)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	cipher_scoreboard sb = new();
	logic [63:0] key_sched [KEY_TABLE_WORDS];
	logic [1:0]  key_len = KL_128;
	bit          calm = 1'b0;     // no idling on either side
	int          hold_off = 0;    // long receiver stall, in cycles

	function automatic logic [7:0] gf_dbl(logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
	endfunction

	function automatic logic [127:0] encrypt_block(logic [127:0] pt);
		logic [7:0]   s[16], t[16], k[16];
		logic [7:0]   a0, a1, a2, a3, al;
		logic [127:0] rk, res;
		int           nr;
		nr = (key_len == KL_128) ? 10 : (key_len == KL_192) ? 12 : 14;
		for (int i = 0; i < 16; i++) s[i] = pt[127 - 8*i -: 8];
		for (int r = 0; r <= nr; r++) begin
			if (r > 0) begin
				for (int c = 0; c < 4; c++)
					for (int w = 0; w < 4; w++)
						t[w + 4*c] = SBOX[s[w + 4*((c + w) % 4)]];
				s = t;
				if (r < nr) begin
					for (int c = 0; c < 16; c += 4) begin
						a0 = s[c]; a1 = s[c+1]; a2 = s[c+2]; a3 = s[c+3];
						al = a0 ^ a1 ^ a2 ^ a3;
						s[c]   = a0 ^ al ^ gf_dbl(a0 ^ a1);
						s[c+1] = a1 ^ al ^ gf_dbl(a1 ^ a2);
						s[c+2] = a2 ^ al ^ gf_dbl(a2 ^ a3);
						s[c+3] = a3 ^ al ^ gf_dbl(a3 ^ a0);
					end
				end
			end
			rk = {(2*r < KEY_TABLE_WORDS) ? key_sched[2*r] : 64'h0,
			      (2*r + 1 < KEY_TABLE_WORDS) ? key_sched[2*r+1] : 64'h0};
			for (int i = 0; i < 16; i++) s[i] ^= rk[127 - 8*i -: 8];
		end
		for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// Called at a falling edge; leaves valid high so that items can follow back to back.
	task automatic send_item(logic k, logic [4:0] idx, logic [63:0] w,
	                         logic [63:0] hi, logic [63:0] lo);
		logic [127:0] ct;
		while (!calm && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		key_word_index <= idx;
		key_word <= w;
		block_high <= hi;
		block_low <= lo;
		do @(posedge clk); while (!in_ready);
		if (k == KIND_KEY) begin
			if (idx < KEY_TABLE_WORDS) key_sched[idx] = w;
		end else begin
			ct = encrypt_block({hi, lo});
			sb.note_block(ct[127:64], ct[63:0]);
		end
		@(negedge clk);
	endtask

	task automatic load_schedule();
		for (int i = 0; i < KEY_TABLE_WORDS; i++)
			send_item(KIND_KEY, i[4:0], rand64(), rand64(), rand64());
	endtask

	task automatic write_key_len(logic [1:0] v);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		key_len = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_block();
		send_item(KIND_BLOCK, 5'($urandom()), rand64(), rand64(), rand64());
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_cipher(cipher_high, cipher_low);
	end
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(0, 99) >= 14);
		end
	end

	initial begin
		#2000000;
		$display("aes_block_encrypt regression: fail");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: full table, out-of-range writes, extreme blocks, each key length.
		load_schedule();
		send_item(KIND_KEY, 5'd30, '1, '0, '0);
		send_item(KIND_KEY, 5'd31, '1, '0, '0);
		send_item(KIND_BLOCK, '0, '0, '0, '0);
		send_item(KIND_BLOCK, '1, '1, '1, '1);
		send_item(KIND_BLOCK, '0, '0, 64'h0011223344556677, 64'h8899aabbccddeeff);
		write_key_len(2'd1);
		send_item(KIND_BLOCK, '0, '0, '1, '0);
		write_key_len(2'd2);
		send_item(KIND_BLOCK, '0, '0, '0, '1);
		write_key_len(2'd3);
		send_item(KIND_BLOCK, '0, '0, 64'h8000000000000001, 64'h0123456789abcdef);

		// Random phases across all key lengths, with key rewrites in between.
		for (int ph = 0; ph < 8; ph++) begin
			write_key_len(2'(ph % 4));
			calm = (ph == 3);
			if (ph == 5) hold_off = 400;
			for (int i = 0; i < 170; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_item(KIND_KEY, 5'($urandom()), rand64(), rand64(), rand64());
				else
					send_block();
			end
			if (ph % 2 == 1) load_schedule();
		end
		calm = 1'b0;
		write_key_len(2'd0);
		for (int i = 0; i < 40; i++) send_block();
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (sb.errors == 0)
			$display("aes_block_encrypt regression: pass");
		else
			$display("aes_block_encrypt regression: fail");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/aesbe_pkg.sv
design/aesbe_ram.sv
design/aesbe_ctrl.sv
design/aesbe_dp.sv
design/aes_block_encrypt.sv
tb/sv/aes_block_encrypt_tb.sv
